[rtl/core/sha256sh_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hash core.
`timescale 1ns / 1ps

package sha256sh_pkg;

    // Input transfer payload: one optional message byte plus the end mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    // Output transfer payload: one digest word and its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } t_out_item;

    // Which compression the shared round unit is running
    typedef enum logic [1:0] {
        PH_ABSORB   = 2'd0,   // block filled by message bytes
        PH_PAD_MORE = 2'd1,   // padding block with no room for the length
        PH_LAST     = 2'd2    // block that carries the bit length
    } t_phase;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;

    localparam logic [5:0]  LENGTH_POS = 6'd56;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] BIT_STEP   = 64'd8;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/core/sha256_stream_hash_core.sv]
// SHA-256 stream hash core: byte packing, padding, iterative compression, digest output.
`timescale 1ns / 1ps

// Byte-serial SHA-256. Each input transfer carries at most one message byte and an
// end mark; bytes pack big-endian into a 16-word block register. An item that neither
// fills a block nor carries the end mark leaves the input free for the next item. The
// byte that completes a block starts a compression on the single round unit, one round
// per cycle: 64 rounds, then a fold into the chaining words, and the input stalls
// throughout. On the end mark the core writes the padding one word per cycle, runs
// one or two compressions, then presents the eight digest words, most significant
// first, one per output transfer, and returns to the initial hash values.
// The input takes no bytes while the round unit compresses a block, so on long
// messages the round unit sets the sustained rate.
module sha256_stream_hash_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  sha256sh_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output sha256sh_pkg::t_out_item o_out_data
);
    import sha256sh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    // Control state
    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_round, n_round;
    logic [5:0]  r_cnt,   n_cnt;     // bytes in current block
    logic [3:0]  r_pidx,  n_pidx;    // padding word pointer
    logic        r_first, n_first;   // next padding word holds the 0x80 byte
    logic        r_pend,  n_pend;    // end mark waits behind a full-block compression
    logic [2:0]  r_oidx,  n_oidx;
    logic [63:0] r_count, n_count;
    logic [31:0] r_h [HASH_WORDS];
    logic [31:0] n_h [HASH_WORDS];

    // Payload: block / schedule window and working variables a..h
    logic [31:0] r_w [BLOCK_WORDS];
    logic [31:0] n_w [BLOCK_WORDS];
    logic [31:0] r_v [HASH_WORDS];
    logic [31:0] n_v [HASH_WORDS];

    logic        in_xfer;
    logic        out_xfer;
    logic [31:0] rd_word;
    logic [31:0] byte_word;
    logic [31:0] pad_word;
    logic [31:0] keep_mask;
    logic [31:0] pad_bits;
    logic [31:0] t1, t2, w_next;
    logic [5:0]  cnt_inc;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data.digest_word = r_h[r_oidx];
    assign o_out_data.word_number = r_oidx;
    assign o_out_data.final_word  = (r_oidx == 3'd7);

    // Single read of the partially filled word
    assign rd_word = r_w[r_cnt[5:2]];
    assign cnt_inc = r_cnt + 6'd1;

    // Merge an incoming byte into its lane
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: byte_word = {i_in_data.data_byte, 24'd0};
            2'd1: byte_word = rd_word | {8'd0, i_in_data.data_byte, 16'd0};
            2'd2: byte_word = rd_word | {16'd0, i_in_data.data_byte, 8'd0};
            2'd3: byte_word = rd_word | {24'd0, i_in_data.data_byte};
        endcase
    end

    // First padding word keeps bytes ahead of the pad position
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin keep_mask = 32'h00000000; pad_bits = {PAD_BYTE, 24'd0}; end
            2'd1: begin keep_mask = 32'hff000000; pad_bits = {8'd0, PAD_BYTE, 16'd0}; end
            2'd2: begin keep_mask = 32'hffff0000; pad_bits = {16'd0, PAD_BYTE, 8'd0}; end
            2'd3: begin keep_mask = 32'hffffff00; pad_bits = {24'd0, PAD_BYTE}; end
        endcase
    end

    always_comb begin
        priority if (r_first) begin
            pad_word = (rd_word & keep_mask) | pad_bits;
        end else if (r_phase == PH_LAST && r_pidx == 4'd14) begin
            pad_word = r_count[63:32];
        end else if (r_phase == PH_LAST && r_pidx == 4'd15) begin
            pad_word = r_count[31:0];
        end else begin
            pad_word = 32'd0;
        end
    end

    // Shared round unit: one compression round and one schedule word per cycle
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_TABLE[r_round] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_round = r_round;
        n_cnt   = r_cnt;
        n_pidx  = r_pidx;
        n_first = r_first;
        n_pend  = r_pend;
        n_oidx  = r_oidx;
        n_count = r_count;
        n_h     = r_h;
        n_w     = r_w;
        n_v     = r_v;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.byte_present) begin
                        n_w[r_cnt[5:2]] = byte_word;
                        n_count         = r_count + BIT_STEP;
                        n_cnt           = cnt_inc;
                    end
                    if (i_in_data.byte_present && r_cnt == 6'd63) begin
                        n_state = ST_COMP;
                        n_round = 6'd0;
                        n_v     = r_h;
                        n_phase = PH_ABSORB;
                        n_pend  = i_in_data.end_of_message;
                    end else if (i_in_data.end_of_message) begin
                        n_state = ST_PAD;
                        n_pidx  = n_cnt[5:2];
                        n_first = 1'b1;
                        n_phase = (n_cnt >= LENGTH_POS) ? PH_PAD_MORE : PH_LAST;
                    end
                end
            end
            ST_PAD: begin
                n_w[r_pidx] = pad_word;
                n_first     = 1'b0;
                n_pidx      = r_pidx + 4'd1;
                if (r_pidx == 4'd15) begin
                    n_state = ST_COMP;
                    n_round = 6'd0;
                    n_v     = r_h;
                end
            end
            ST_COMP: begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[BLOCK_WORDS - 1] = w_next;
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                unique case (r_phase)
                    PH_ABSORB: begin
                        if (r_pend) begin
                            n_state = ST_PAD;
                            n_pidx  = 4'd0;
                            n_first = 1'b1;
                            n_phase = PH_LAST;
                            n_pend  = 1'b0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    PH_PAD_MORE: begin
                        n_state = ST_PAD;
                        n_pidx  = 4'd0;
                        n_first = 1'b0;
                        n_phase = PH_LAST;
                    end
                    PH_LAST: begin
                        n_state = ST_OUT;
                        n_oidx  = 3'd0;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_h     = H_INIT;
                        n_count = 64'd0;
                        n_cnt   = 6'd0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_ABSORB;
            r_round <= 6'd0;
            r_cnt   <= 6'd0;
            r_pidx  <= 4'd0;
            r_first <= 1'b0;
            r_pend  <= 1'b0;
            r_oidx  <= 3'd0;
            r_count <= 64'd0;
            r_h     <= H_INIT;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_round <= n_round;
            r_cnt   <= n_cnt;
            r_pidx  <= n_pidx;
            r_first <= n_first;
            r_pend  <= n_pend;
            r_oidx  <= n_oidx;
            r_count <= n_count;
            r_h     <= n_h;
        end
    end

    // Block / schedule window and working variables
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    // Rounds advance one per cycle without a break
    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_round != 6'd63)
        |=> (r_state == ST_COMP && r_round == $past(r_round) + 6'd1))
        else $error("compression round sequence broken");

    // Digest words come out in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_out_data.final_word)
        |=> (o_out_valid && o_out_data.word_number == $past(o_out_data.word_number) + 3'd1))
        else $error("digest word order broken");

    // After the last digest word the hash state is back at its initial value
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.final_word)
        |=> (r_h[0] == H_INIT[0] && r_count == 64'd0 && r_cnt == 6'd0 && !o_in_stall))
        else $error("hash state not restarted after digest");

    // Input and output never take transfers in the same cycle
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input ready while digest pending");

endmodule

[test/sha256_stream_hash_core_test.sv]
// Self-checking testbench for the SHA-256 stream hash core, with its own SHA-256 predictor.
`timescale 1ns / 1ps

module sha256_stream_hash_core_test;
    import sha256sh_pkg::*;

    localparam int IDLE_LIMIT   = 3000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 100;    // covers a compression still in flight
    localparam int LONG_HOLD    = 350;    // receiver hold-off that backs up the core
    localparam int ITEM_TARGET  = 430;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [6:0] LEN_OFFSET = 7'd56;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Pending input transfer; hold_for_drain makes the sender wait for all digests first
    typedef struct packed {
        t_in_item item;
        logic     hold_for_drain;
    } t_pending_item;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data  = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_pending_item stream_q [$];
    t_out_item     digest_q [$];

    // Predictor state
    logic [31:0] hash_h [8];
    logic [63:0] bit_count;
    logic [31:0] blk [16];
    logic [5:0]  blk_bytes;

    logic in_accepted = 1'b0;
    int   fail_count  = 0;
    int   out_count   = 0;
    int   queued_items = 0;

    // Sender and receiver pacing
    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    int holds_done = 0;

    sha256_stream_hash_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_h    = SHA_IV;
        bit_count = '0;
        blk_bytes = '0;
    endfunction

    // Big-endian byte insert; the first byte of a word clears the rest of it
    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] v);
        int sh;
        sh = (3 - int'(pos[1:0])) * 8;
        if (pos[1:0] == 2'd0) begin
            blk[pos[5:2]] = {24'd0, v} << sh;
        end else begin
            blk[pos[5:2]] = blk[pos[5:2]] | ({24'd0, v} << sh);
        end
    endfunction

    // 64 rounds over blk, folded into hash_h
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] wi, x15, x2, s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
        e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wi = w[r];
            end else begin
                x15 = w[(r + 1) % 16];
                x2  = w[(r + 14) % 16];
                s0  = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
                s1  = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
                wi  = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
                w[r % 16] = wi;
            end
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + SHA_K[r] + wi;
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endfunction

    // Absorb one accepted item; on the end mark, pad and queue the eight digest words
    function automatic void hash_item(input t_in_item it);
        logic [6:0] pos;
        t_out_item  word;
        if (it.byte_present) begin
            put_byte(blk_bytes, it.data_byte);
            bit_count = bit_count + 64'd8;
            blk_bytes = blk_bytes + 6'd1;
            if (blk_bytes == 6'd0) compress_block();
        end
        if (it.end_of_message) begin
            pos = {1'b0, blk_bytes};
            put_byte(pos[5:0], PAD_MARK);
            pos++;
            // no room for the length: zero-fill and run an extra block
            if (pos > LEN_OFFSET) begin
                while (pos < 7'd64) begin
                    put_byte(pos[5:0], 8'h00);
                    pos++;
                end
                compress_block();
                pos = '0;
            end
            while (pos < LEN_OFFSET) begin
                put_byte(pos[5:0], 8'h00);
                pos++;
            end
            blk[14] = bit_count[63:32];
            blk[15] = bit_count[31:0];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_h[i];
                word.word_number = 3'(i);
                word.final_word  = (i == 7);
                digest_q.push_back(word);
            end
            restart_hash();
        end
    endfunction

    task automatic push_item(input logic [7:0] d, input logic p, input logic e,
                             input logic hold);
        t_pending_item pi;
        pi.item.data_byte      = d;
        pi.item.byte_present   = p;
        pi.item.end_of_message = e;
        pi.hold_for_drain      = hold;
        stream_q.push_back(pi);
        queued_items++;
    endtask

    // One message with random content, stray empty items and either end form
    task automatic push_message(input int len, input logic hold);
        int         fill;
        logic       join_end;
        logic       first;
        logic [7:0] d;
        fill     = $urandom_range(0, 7);
        join_end = $urandom_range(0, 1);
        first    = hold;
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom_range(0, 255));
            push_item(d, 1'b1, (n == len - 1) && join_end, first);
            first = 1'b0;
        end
        if (len == 0 || !join_end) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
        end
    endtask

    // Stimulus, then end-of-run check
    initial begin
        int len;
        int sel;
        int msg_idx;
        restart_hash();

        // Empty message
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        // Byte absent then a single 0xff byte together with the end mark
        push_item(8'hff, 1'b0, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b1, 1'b0);
        // Single zero byte with the end mark
        push_item(8'h00, 1'b1, 1'b1, 1'b0);
        // "abc" with an ignored byte inside and the end mark on its own item
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h5a, 1'b0, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1, 1'b0);
        // Empty message whose ignored byte carries data
        push_item(8'ha5, 1'b0, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1, 1'b0);

        // Random messages, weighted toward the padding boundaries
        msg_idx = 0;
        while (queued_items < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                len = $urandom_range(0, 12);
            end else if (sel < 7) begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end else if (sel == 7) begin
                len = $urandom_range(0, 130);
            end else begin
                len = $urandom_range(13, 54);
            end
            // cap the last message's length at the items left in the budget
            if (len > ITEM_TARGET - queued_items) len = ITEM_TARGET - queued_items;
            push_message(len, (msg_idx == 4) || (msg_idx == 10));
            msg_idx++;
        end

        while (stream_q.size() != 0 || digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sha256_stream_hash_core_test passed");
        end else begin
            $display("sha256_stream_hash_core_test failed");
        end
        $finish;
    end

    // Input driver: bursts with random gaps, optional wait for all digests
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (i_rst_n) begin
            if (in_accepted) begin
                stream_q.delete(0);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_q.size() != 0 &&
                             (!stream_q[0].hold_for_drain || digest_q.size() == 0)) begin
                    nxt_valid = 1'b1;
                    nxt_data  = stream_q[0].item;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Output stall pattern, with two long hold-offs
    always @(negedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (holds_done < 2 && out_count >= ((holds_done == 0) ? 13 : 100)) begin
            holds_done++;
            hold_left = LONG_HOLD;
            nxt_stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: nxt_stall = 1'b0;
                1: nxt_stall = ($urandom_range(0, 3) == 0);
                2: nxt_stall = ($urandom_range(0, 3) != 0);
                default: nxt_stall = ~i_out_stall;
            endcase
        end
        i_out_stall <= nxt_stall;
    end

    // Monitor: feed accepted input to the predictor, check each output transfer
    always @(posedge i_clk) begin
        t_out_item exp_w;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) hash_item(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                out_count++;
                if (digest_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected digest transfer: expected none, actual %h/%0d/%0d",
                             $time, o_out_data.digest_word, o_out_data.word_number,
                             o_out_data.final_word);
                end else begin
                    exp_w = digest_q.pop_front();
                    if (o_out_data.digest_word !== exp_w.digest_word) begin
                        fail_count++;
                        $display("%0t: digest_word mismatch: expected %h, actual %h",
                                 $time, exp_w.digest_word, o_out_data.digest_word);
                    end
                    if (o_out_data.word_number !== exp_w.word_number) begin
                        fail_count++;
                        $display("%0t: word_number mismatch: expected %0d, actual %0d",
                                 $time, exp_w.word_number, o_out_data.word_number);
                    end
                    if (o_out_data.final_word !== exp_w.final_word) begin
                        fail_count++;
                        $display("%0t: final_word mismatch: expected %0d, actual %0d",
                                 $time, exp_w.final_word, o_out_data.final_word);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("sha256_stream_hash_core_test failed");
        $finish;
    end

endmodule
